// ===== rtl/aes_pkg.sv =====
package aes_pkg;

  localparam int ROUNDS = 10;
  localparam int CNT_W = $clog2(ROUNDS + 1);
  localparam int CFG_INDEX_W = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW = 8'd1;

  localparam logic [7:0] RCON_FIRST = 8'h01;
  localparam logic [7:0] RCON_LAST = 8'h36;
  localparam logic [7:0] GF_POLY = 8'h1b;

  typedef enum logic [1:0] {
    ST_KEYGEN,
    ST_IDLE,
    ST_RUN
  } state_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
  endfunction

  function automatic logic [7:0] xtime_inv(input logic [7:0] x);
    return x[0] ? ({1'b0, x[7:1] ^ GF_POLY[7:1]} | 8'h80) : {1'b0, x[7:1]};
  endfunction

  function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
    return s[127 - 8*i -: 8];
  endfunction

  function automatic logic [31:0] sub_rot(input logic [31:0] w);
    return {SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
  endfunction

  // One key schedule step, forward or backward.
  function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc,
                                            input logic inv);
    logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = sub_rot(inv ? (w3 ^ w2) : w3) ^ {rc, 24'h0};
    if (inv) begin
      n3 = w3 ^ w2;
      n2 = w2 ^ w1;
      n1 = w1 ^ w0;
      n0 = w0 ^ t;
    end else begin
      n0 = w0 ^ t;
      n1 = w1 ^ n0;
      n2 = w2 ^ n1;
      n3 = w3 ^ n2;
    end
    return {n0, n1, n2, n3};
  endfunction

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic last);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[c*4 + r] = SBOX[get_byte(s, ((c + r) % 4) * 4 + r)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[c*4];
      a1 = t[c*4 + 1];
      a2 = t[c*4 + 2];
      a3 = t[c*4 + 3];
      if (!last) begin
        t[c*4]     = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        t[c*4 + 1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
        t[c*4 + 2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
        t[c*4 + 3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
    end
    for (int i = 0; i < 16; i++) begin
      o[127 - 8*i -: 8] = t[i];
    end
    return o ^ k;
  endfunction

  function automatic logic [7:0] mul9(input logic [7:0] x);
    return xtime(xtime(xtime(x))) ^ x;
  endfunction

  function automatic logic [7:0] mul11(input logic [7:0] x);
    return xtime(xtime(xtime(x))) ^ xtime(x) ^ x;
  endfunction

  function automatic logic [7:0] mul13(input logic [7:0] x);
    return xtime(xtime(xtime(x))) ^ xtime(xtime(x)) ^ x;
  endfunction

  function automatic logic [7:0] mul14(input logic [7:0] x);
    return xtime(xtime(xtime(x))) ^ xtime(xtime(x)) ^ xtime(x);
  endfunction

  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic last);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[c*4 + r] = INV_SBOX[get_byte(s, ((c + 4 - r) % 4) * 4 + r)] ^
                     get_byte(k, c*4 + r);
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[c*4];
      a1 = t[c*4 + 1];
      a2 = t[c*4 + 2];
      a3 = t[c*4 + 3];
      if (!last) begin
        t[c*4]     = mul14(a0) ^ mul11(a1) ^ mul13(a2) ^ mul9(a3);
        t[c*4 + 1] = mul9(a0) ^ mul14(a1) ^ mul11(a2) ^ mul13(a3);
        t[c*4 + 2] = mul13(a0) ^ mul9(a1) ^ mul14(a2) ^ mul11(a3);
        t[c*4 + 3] = mul11(a0) ^ mul13(a1) ^ mul9(a2) ^ mul14(a3);
      end
    end
    for (int i = 0; i < 16; i++) begin
      o[127 - 8*i -: 8] = t[i];
    end
    return o;
  endfunction

endpackage

// ===== rtl/aes128_block_cipher_core.sv =====
// AES-128 block cipher, ECB mode.
// Input channel (in_valid/in_ready): kind (0 encrypt, 1 decrypt) and a
// 16-byte block as block_high/block_low, byte 0 in the top bits of block_high.
// Output channel (out_valid/out_ready): result_high/result_low, same layout.
// Config channel (cfg_valid/cfg_ready): cfg_index 0 writes key_high, 1 writes
// key_low, other indexes are dropped. Write only while the block is idle.
// The key add happens at accept, then one round per cycle over a
// single shared round unit with an on-the-fly key schedule; the final
// round holds while the output register is full. A new item is accepted
// as soon as the round unit is free and the previous result sits in the
// output register.
// After reset and after each key write, the key schedule runs forward to
// find the last round key used to start decryption; the input and config
// channels are not ready meanwhile. Reset key is all zero.
// When the receiver stalls, the finished round waits in the round unit until
// the output register frees up; no item is dropped.
module aes128_block_cipher_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                kind,
  input  logic [63:0]                         block_high,
  input  logic [63:0]                         block_low,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [63:0]                         result_high,
  output logic [63:0]                         result_low,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [aes_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [63:0]                         cfg_data
);

  aes_pkg::state_t state, state_next;

  logic [63:0]                 key_high, key_low;
  logic [127:0]                last_key;
  logic [127:0]                st;
  logic [127:0]                rk;
  logic [7:0]                  rcon;
  logic [aes_pkg::CNT_W-1:0]   cnt;
  logic                        dec;
  logic [127:0]                rk_step;
  logic [127:0]                round_out;
  logic                        final_round;
  logic                        out_free;
  logic                        in_take;
  logic                        cfg_take;
  logic                        key_write;

  assign rk_step     = aes_pkg::key_step(rk, rcon, dec && (state == aes_pkg::ST_RUN));
  assign final_round = (cnt == aes_pkg::CNT_W'(aes_pkg::ROUNDS));
  assign round_out   = dec ? aes_pkg::dec_round(st, rk_step, final_round)
                           : aes_pkg::enc_round(st, rk_step, final_round);
  assign out_free    = !out_valid || out_ready;
  assign in_take     = in_valid && in_ready;
  assign cfg_take    = cfg_valid && cfg_ready;
  assign key_write   = cfg_take && (cfg_index == aes_pkg::REG_KEY_HIGH ||
                                    cfg_index == aes_pkg::REG_KEY_LOW);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aes_pkg::ST_KEYGEN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cfg_ready  = 1'b0;
    unique case (state)
      aes_pkg::ST_KEYGEN: begin
        if (cnt == aes_pkg::CNT_W'(aes_pkg::ROUNDS - 1)) begin
          state_next = aes_pkg::ST_IDLE;
        end
      end
      aes_pkg::ST_IDLE: begin
        in_ready  = !cfg_valid;
        cfg_ready = 1'b1;
        if (cfg_valid && (cfg_index == aes_pkg::REG_KEY_HIGH ||
                          cfg_index == aes_pkg::REG_KEY_LOW)) begin
          state_next = aes_pkg::ST_KEYGEN;
        end else if (in_valid && !cfg_valid) begin
          state_next = aes_pkg::ST_RUN;
        end
      end
      aes_pkg::ST_RUN: begin
        if (final_round && out_free) begin
          state_next = aes_pkg::ST_IDLE;
        end
      end
      default: state_next = aes_pkg::ST_KEYGEN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high  <= '0;
      key_low   <= '0;
      rk        <= '0;
      rcon      <= aes_pkg::RCON_FIRST;
      cnt       <= '0;
      dec       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !(state == aes_pkg::ST_RUN && final_round)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        aes_pkg::ST_KEYGEN: begin
          rk   <= rk_step;
          rcon <= aes_pkg::xtime(rcon);
          cnt  <= cnt + 1'b1;
          if (cnt == aes_pkg::CNT_W'(aes_pkg::ROUNDS - 1)) begin
            last_key <= rk_step;
          end
        end
        aes_pkg::ST_IDLE: begin
          if (key_write) begin
            dec  <= 1'b0;
            cnt  <= '0;
            rcon <= aes_pkg::RCON_FIRST;
            if (cfg_index == aes_pkg::REG_KEY_HIGH) begin
              key_high <= cfg_data;
              rk       <= {cfg_data, key_low};
            end else begin
              key_low <= cfg_data;
              rk      <= {key_high, cfg_data};
            end
          end else if (in_take) begin
            dec <= kind;
            cnt <= aes_pkg::CNT_W'(1);
            if (kind) begin
              st   <= {block_high, block_low} ^ last_key;
              rk   <= last_key;
              rcon <= aes_pkg::RCON_LAST;
            end else begin
              st   <= {block_high, block_low} ^ {key_high, key_low};
              rk   <= {key_high, key_low};
              rcon <= aes_pkg::RCON_FIRST;
            end
          end
        end
        aes_pkg::ST_RUN: begin
          if (!final_round) begin
            st   <= round_out;
            rk   <= rk_step;
            rcon <= dec ? aes_pkg::xtime_inv(rcon) : aes_pkg::xtime(rcon);
            cnt  <= cnt + 1'b1;
          end else if (out_free) begin
            result_high <= round_out[127:64];
            result_low  <= round_out[63:0];
            out_valid   <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != aes_pkg::ST_IDLE) |-> !in_ready && !cfg_ready)
    else $error("input or config ready while busy");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == aes_pkg::ST_RUN) |-> (cnt != '0) && (cnt <= aes_pkg::CNT_W'(aes_pkg::ROUNDS)))
    else $error("round count out of range");

  a_key_write_regen: assert property (@(posedge clk) disable iff (rst)
    key_write |=> (state == aes_pkg::ST_KEYGEN) && (cnt == '0))
    else $error("key write did not restart key schedule");

  a_result_from_run: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == aes_pkg::ST_RUN)
    else $error("result produced outside a run");

endmodule

// ===== dv/tb_top.sv =====
module tb_top;

  typedef struct packed {
    logic        kind;
    logic [63:0] hi;
    logic [63:0] lo;
  } block_item_t;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } cipher_out_t;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic kind = 1'b0;
  logic [63:0] block_high = '0;
  logic [63:0] block_low = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [63:0] result_high;
  logic [63:0] result_low;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [aes_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  aes128_block_cipher_core dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  block_item_t pending_blocks[$];
  cipher_out_t expected_blocks[$];
  logic [7:0] sbox_fwd [256];
  logic [7:0] sbox_inv [256];
  logic [63:0] key_hi_reg, key_lo_reg;
  logic [127:0] round_keys [11];
  int errors = 0;
  int cycles = 0;
  int hold_off = 0;
  bit long_stall_req = 1'b0;
  bit stim_done = 1'b0;

  function automatic logic [7:0] gmul2(logic [7:0] x);
    return (x << 1) ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(logic [7:0] x, int y);
    logic [7:0] acc;
    acc = 0;
    while (y != 0) begin
      if (y[0]) acc ^= x;
      x = gmul2(x);
      y >>= 1;
    end
    return acc;
  endfunction

  function automatic void build_tables();
    logic [7:0] p, q, x;
    p = 1;
    q = 1;
    sbox_fwd[0] = 8'h63;
    do begin
      p = p ^ (p << 1) ^ (p[7] ? 8'h1b : 8'h00);
      q ^= q << 1;
      q ^= q << 2;
      q ^= q << 4;
      if (q[7]) q ^= 8'h09;
      x = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]} ^ {q[3:0], q[7:4]};
      sbox_fwd[p] = x ^ 8'h63;
    end while (p != 1);
    for (int v = 0; v < 256; v++) sbox_inv[sbox_fwd[v]] = v[7:0];
  endfunction

  function automatic void expand_round_keys();
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0] rc;
    rc = 8'h01;
    {w[0], w[1], w[2], w[3]} = {key_hi_reg, key_lo_reg};
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {sbox_fwd[t[23:16]], sbox_fwd[t[15:8]], sbox_fwd[t[7:0]], sbox_fwd[t[31:24]]}
            ^ {rc, 24'h0};
        rc = gmul2(rc);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) round_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endfunction

  function automatic cipher_out_t cipher_block(block_item_t it);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a [4];
    logic [127:0] st;
    int m [4];
    st = {it.hi, it.lo};
    for (int i = 0; i < 16; i++) s[i] = st[127-8*i -: 8];
    for (int step = 0; step <= 10; step++) begin
      int r;
      r = it.kind ? 10 - step : step;
      if (step > 0) begin
        for (int c = 0; c < 4; c++)
          for (int rw = 0; rw < 4; rw++)
            t[c*4+rw] = it.kind ? sbox_inv[s[((c+4-rw)%4)*4+rw]]
                                : sbox_fwd[s[((c+rw)%4)*4+rw]];
        s = t;
        if (!it.kind && step != 10) begin
          m = '{2, 3, 1, 1};
          for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) a[k] = s[c*4+k];
            for (int rw = 0; rw < 4; rw++) begin
              s[c*4+rw] = 0;
              for (int k = 0; k < 4; k++) s[c*4+rw] ^= gmul(a[k], m[(k+4-rw)%4]);
            end
          end
        end
      end
      for (int i = 0; i < 16; i++) s[i] ^= round_keys[r][127-8*i -: 8];
      if (it.kind && step > 0 && step != 10) begin
        m = '{14, 11, 13, 9};
        for (int c = 0; c < 4; c++) begin
          for (int k = 0; k < 4; k++) a[k] = s[c*4+k];
          for (int rw = 0; rw < 4; rw++) begin
            s[c*4+rw] = 0;
            for (int k = 0; k < 4; k++) s[c*4+rw] ^= gmul(a[k], m[(k+4-rw)%4]);
          end
        end
      end
    end
    for (int i = 0; i < 16; i++) st[127-8*i -: 8] = s[i];
    return '{hi: st[127:64], lo: st[63:0]};
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_blocks.push_back(cipher_block('{kind, block_high, block_low}));
        in_gap = gap_len();
      end
      if (!(in_valid && !in_ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_blocks.size() > 0) begin
          block_item_t it;
          it = pending_blocks.pop_front();
          in_valid <= 1'b1;
          kind <= it.kind;
          block_high <= it.hi;
          block_low <= it.lo;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  int out_gap = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected result %h %h", $time, result_high, result_low);
          errors++;
        end else begin
          cipher_out_t e;
          e = expected_blocks.pop_front();
          if (e.hi !== result_high) begin
            $display("%0t: result_high expected %h actual %h", $time, e.hi, result_high);
            errors++;
          end
          if (e.lo !== result_low) begin
            $display("%0t: result_low expected %h actual %h", $time, e.lo, result_low);
            errors++;
          end
        end
      end
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        hold_off = 200;
      end
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_gap = gap_len();
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_key(logic [aes_pkg::CFG_INDEX_W-1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == aes_pkg::REG_KEY_HIGH) key_hi_reg = val;
    else if (idx == aes_pkg::REG_KEY_LOW) key_lo_reg = val;
    expand_round_keys();
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_blocks.size() > 0 || in_valid || expected_blocks.size() > 0);
    repeat (15) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic add_block(logic k, logic [63:0] h, logic [63:0] l);
    pending_blocks.push_back('{k, h, l});
  endtask

  initial begin
    block_item_t it;
    cipher_out_t ct;
    build_tables();
    key_hi_reg = '0;
    key_lo_reg = '0;
    expand_round_keys();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // zero key after reset
    add_block(1'b0, '0, '0);
    add_block(1'b1, '0, '0);
    add_block(1'b0, '1, '1);
    add_block(1'b1, '1, '1);
    drain();
    write_key(aes_pkg::REG_KEY_HIGH, 64'h0001020304050607);
    write_key(aes_pkg::REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
    add_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    add_block(1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    add_block(1'b0, 64'h8000000000000000, 64'h0000000000000001);
    add_block(1'b1, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    drain();
    write_key(8'd2, rand64());
    write_key(8'hff, rand64());
    write_key(aes_pkg::REG_KEY_HIGH, '1);
    write_key(aes_pkg::REG_KEY_LOW, '1);
    add_block(1'b0, '0, '1);
    add_block(1'b1, '1, '0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_key(aes_pkg::REG_KEY_HIGH, ph == 5 ? 64'h0 : rand64());
      write_key(aes_pkg::REG_KEY_LOW, ph == 5 ? 64'h0 : rand64());
      if (ph == 2) long_stall_req = 1'b1;
      for (int n = 0; n < 170; n++) begin
        it = '{1'($urandom_range(0, 1)), rand64(), rand64()};
        // round trip: decrypt a ciphertext of the current key
        if ($urandom_range(0, 3) == 0) begin
          ct = cipher_block('{1'b0, it.hi, it.lo});
          it = '{1'b1, ct.hi, ct.lo};
        end
        pending_blocks.push_back(it);
      end
      drain();
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/aes_pkg.sv
rtl/aes128_block_cipher_core.sv
dv/tb_top.sv
